@@ rtl/gmo_pkg.sv @@
// shared constants, types and the quarter-wave sine table of the oscillator
`timescale 1ns / 1ps
`default_nettype none

package gmo_pkg;

  // phase accumulator and sine table geometry
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QBITS          = SINE_ADDR_BITS - 2;
  localparam int QSIZE          = 1 << QBITS;

  // field widths
  localparam int STEP_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int WAVE_W   = 3;
  localparam int GLIDE_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W    = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_SAMPLES = 2'd1;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW_UP   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAW_DOWN = 3'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_SAMPLE,
    S_OUT
  } state_t;

  typedef logic [MAG_W-1:0] qsine_tab_t [QSIZE];

  // odd polynomial coefficients in Q2.30
  localparam longint SINE_COEF [6] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306,
    -64'sd5026995, 64'sd172272, -64'sd3864
  };

  // signed times non-negative Q30, truncated toward zero
  function automatic longint mul_q30(longint a, longint b);
    longint m;
    if (a < 0) begin
      m = ((-a) * b) >>> 30;
      return -m;
    end
    return (a * b) >>> 30;
  endfunction

  // sin(pi/2 * k / QSIZE) in Q1.15, rounded half up, clamped
  function automatic logic [MAG_W-1:0] quarter_sine(int k);
    longint u;
    longint u2;
    longint acc;
    longint s;
    longint r;
    u   = longint'(k) << (30 - QBITS);
    u2  = (u * u) >>> 30;
    acc = SINE_COEF[5];
    for (int i = 4; i >= 0; i--) begin
      acc = SINE_COEF[i] + mul_q30(acc, u2);
    end
    s = mul_q30(acc, u);
    if (s < 0) s = 0;
    r = (s + (64'sd1 << 14)) >>> 15;
    if (r > 32767) r = 32767;
    return r[MAG_W-1:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int k = 0; k < QSIZE; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  // entries 0 .. QSIZE-1, and the quarter-cycle peak on its own
  localparam qsine_tab_t       QSINE     = build_qsine();
  localparam logic [MAG_W-1:0] QSINE_TOP = quarter_sine(QSIZE);

endpackage

`default_nettype wire

@@ rtl/gmo_div.sv @@
// bit-serial restoring divider: unsigned step difference over glide count
`timescale 1ns / 1ps
`default_nettype none

module gmo_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [gmo_pkg::STEP_W-1:0]    dividend,
  input  wire [gmo_pkg::GLIDE_W-1:0]   divisor,
  output logic                         done,
  output logic [gmo_pkg::STEP_W-1:0]   quotient
);
  import gmo_pkg::*;

  localparam int CNT_W = $clog2(STEP_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [STEP_W-1:0]  dvd;
  logic [GLIDE_W-1:0] rem;
  logic [GLIDE_W-1:0] dsr;

  logic [GLIDE_W:0]   trial;
  logic [GLIDE_W:0]   trial_sub;
  logic               fits;
  logic [GLIDE_W-1:0] rem_next;

  // one quotient bit per cycle
  always_comb begin
    trial     = {rem, dvd[STEP_W-1]};
    trial_sub = trial - {1'b0, dsr};
    fits      = (trial >= {1'b0, dsr});
    rem_next  = fits ? trial_sub[GLIDE_W-1:0] : trial[GLIDE_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top, quotient shifts in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[STEP_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

@@ rtl/gmo_wave.sv @@
// two-stage waveform generator from the top phase bits
`timescale 1ns / 1ps
`default_nettype none

module gmo_wave (
  input  wire                                   clk,
  input  wire [gmo_pkg::PHASE_BITS-1:0]         phase,
  input  wire [gmo_pkg::WAVE_W-1:0]             wave_select,
  output logic signed [gmo_pkg::SAMPLE_W-1:0]   sample
);
  import gmo_pkg::*;

  localparam logic signed [17:0] HALF    = 18'sd32768;
  localparam logic signed [17:0] POS_MAX = 18'sd32767;

  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [QBITS:0]            k;
  logic [MAG_W-1:0]          qs;

  logic [MAG_W-1:0]    s1_mag;
  logic                s1_neg;
  logic [SAMPLE_W-1:0] s1_t;

  logic signed [17:0] t_s;
  logic signed [17:0] d;
  logic signed [17:0] d_abs;
  logic signed [17:0] mag_s;
  logic signed [17:0] v;

  // quarter-wave fold and table read
  always_comb begin
    idx  = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    k    = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, idx[QBITS-1:0]})
                   : {1'b0, idx[QBITS-1:0]};
    qs   = k[QBITS] ? QSINE_TOP : QSINE[k[QBITS-1:0]];
  end

  always_ff @(posedge clk) begin
    s1_mag <= qs;
    s1_neg <= quad[1];
    s1_t   <= phase[PHASE_BITS-1 -: SAMPLE_W];
  end

  // shape select and saturation
  always_comb begin
    t_s   = $signed({2'b00, s1_t});
    d     = t_s - HALF;
    d_abs = d[17] ? -d : d;
    mag_s = $signed({3'b000, s1_mag});
    unique case (wave_select)
      WAVE_SINE:     v = s1_neg ? -mag_s : mag_s;
      WAVE_TRIANGLE: v = (d_abs <<< 1) - HALF;
      WAVE_SAW_UP:   v = t_s - HALF;
      WAVE_SAW_DOWN: v = HALF - t_s;
      default:       v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    sample <= (v > POS_MAX) ? POS_MAX[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/gliding_multi_waveform_oscillator_core.sv @@
// gliding multi-waveform oscillator: sequencer, step glide, phase accumulator
// a request is accepted in S_IDLE and passes S_SETUP, S_SAMPLE and S_OUT, where its
// result is loaded into the output register; with a new target and nonzero glide it
// also waits in S_DIV for the serial divider; the next request is taken only in S_IDLE
// an output register holds the result so the next request is taken while it waits
// reset (rst, synchronous): phase, step, glide state and configuration registers go to zero
`timescale 1ns / 1ps
`default_nettype none

module gliding_multi_waveform_oscillator_core (
  input  wire                                 clk,
  input  wire                                 rst,
  // request in; tdata: target_step[31:0]
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [gmo_pkg::STEP_W-1:0]           s_axis_tdata,
  // result out; tdata: sample_out[15:0]
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [gmo_pkg::SAMPLE_W-1:0]        m_axis_tdata,
  // register writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [gmo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [gmo_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gmo_pkg::*;

  state_t state;
  state_t state_next;

  logic [WAVE_W-1:0]     wave_select;
  logic [GLIDE_W-1:0]    glide_samples;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [STEP_W-1:0]     target;
  logic [STEP_W-1:0]     held_target;
  logic [STEP_W-1:0]     current_step;
  logic [STEP_W-1:0]     ramp_delta;
  logic [GLIDE_W-1:0]    ramp_left;
  logic                  delta_neg;
  logic [SAMPLE_W-1:0]   sample_hold;

  logic                  new_target;
  logic                  glide_on;
  logic                  div_start;
  logic                  div_done;
  logic                  out_load;
  logic [STEP_W:0]       diff;
  logic [STEP_W-1:0]     diff_mag;
  logic [STEP_W-1:0]     quotient;
  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS-1:0] phase_add;
  logic signed [SAMPLE_W-1:0] wave_sample;

  // step difference and its magnitude, target change, glide flag and phase increment
  always_comb begin
    new_target = (target != held_target);
    glide_on   = (glide_samples != '0);
    diff       = {1'b0, target} - {1'b0, current_step};
    diff_mag   = diff[STEP_W] ? (~diff[STEP_W-1:0] + 1'b1) : diff[STEP_W-1:0];
    step_wide  = {current_step, {PHASE_BITS{1'b0}}};
    phase_add  = step_wide[PHASE_BITS+STEP_W-1 -: PHASE_BITS];
  end

  gmo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (glide_samples),
    .done     (div_done),
    .quotient (quotient)
  );

  gmo_wave u_wave (
    .clk         (clk),
    .phase       (phase_acc),
    .wave_select (wave_select),
    .sample      (wave_sample)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_SETUP;
      S_SETUP:  state_next = (new_target && glide_on) ? S_DIV : S_SAMPLE;
      S_DIV:    if (div_done) state_next = S_SAMPLE;
      S_SAMPLE: state_next = S_OUT;
      S_OUT:    if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_SETUP:  div_start = new_target && glide_on;
      S_OUT:    out_load = !m_axis_tvalid || m_axis_tready;
      default:  ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select   <= '0;
      glide_samples <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WAVE_SELECT) wave_select <= cfg_data[WAVE_W-1:0];
      if (cfg_index == REG_GLIDE_SAMPLES) glide_samples <= cfg_data[GLIDE_W-1:0];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) target <= s_axis_tdata;
  end

  // glide state, step and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      held_target  <= '0;
      current_step <= '0;
      ramp_delta   <= '0;
      ramp_left    <= '0;
      delta_neg    <= 1'b0;
    end else begin
      unique case (state)
        S_SETUP: begin
          if (new_target) begin
            held_target <= target;
            if (glide_on) begin
              ramp_left <= glide_samples;
              delta_neg <= diff[STEP_W];
            end else begin
              current_step <= target;
              ramp_left    <= '0;
              ramp_delta   <= '0;
            end
          end
        end
        S_DIV: begin
          if (div_done) ramp_delta <= delta_neg ? (~quotient + 1'b1) : quotient;
        end
        S_SAMPLE: begin
          if (ramp_left != '0) begin
            ramp_left <= ramp_left - 1'b1;
            if (ramp_left == GLIDE_W'(1)) begin
              current_step <= held_target;
            end else begin
              current_step <= current_step + ramp_delta;
            end
          end
        end
        S_OUT: begin
          if (out_load) phase_acc <= phase_acc + phase_add;
        end
        default: ;
      endcase
    end
  end

  // sample taken from the phase before this request's advance
  always_ff @(posedge clk) begin
    if (state == S_SAMPLE) sample_hold <= wave_sample;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= sample_hold;
  end

  // last glide tick lands exactly on the target
  a_glide_lands: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAMPLE && ramp_left == GLIDE_W'(1)) |=> (current_step == held_target))
    else $error("glide did not land on target");

  // zero glide jumps at once
  a_zero_glide_jump: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && new_target && !glide_on) |=> (current_step == held_target))
    else $error("zero glide did not jump");

  // step holds when no glide is running
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAMPLE && ramp_left == '0) |=> $stable(current_step))
    else $error("step moved without a glide");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside its wait state");

endmodule

`default_nettype wire

@@ verif/tb_gliding_multi_waveform_oscillator_core.sv @@
// self-checking testbench for the gliding multi-waveform oscillator core
`timescale 1ns / 1ps

module tb_gliding_multi_waveform_oscillator_core;
  import gmo_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS   = 180;
  localparam int STALL_LIMIT  = 2000;
  localparam int SINE_SIZE    = 1 << SINE_ADDR_BITS;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [STEP_W-1:0]     s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // oscillator state as the testbench tracks it
  logic [PHASE_BITS-1:0] osc_phase;
  logic [STEP_W-1:0]     osc_step;
  logic [STEP_W-1:0]     osc_target;
  longint                osc_delta;
  logic [GLIDE_W-1:0]    osc_ramp;
  logic [WAVE_W-1:0]     osc_wave;
  logic [GLIDE_W-1:0]    osc_glide;
  int                    sine_lut [SINE_SIZE];

  logic [SAMPLE_W-1:0]   pending_samples [$];
  logic [SAMPLE_W-1:0]   want_sample;
  int                    mismatch_count;
  int                    quiet_cycles;
  int                    stall_left;
  bit                    calm;

  gliding_multi_waveform_oscillator_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // odd sine polynomial coefficients, Q2.30
  function automatic longint poly_coef(int i);
    case (i)
      0: return 64'sd1686629713;
      1: return -64'sd693598668;
      2: return 64'sd85569306;
      3: return -64'sd5026995;
      4: return 64'sd172272;
      default: return -64'sd3864;
    endcase
  endfunction

  // signed q30 times non-negative q30, truncated toward zero
  function automatic longint q30_product(longint a, longint b);
    if (a < 0) return -(((-a) * b) >>> 30);
    return (a * b) >>> 30;
  endfunction

  // first-quadrant sine magnitude, rounded half up to q1.15
  function automatic int sine_quarter(int k);
    longint u;
    longint u2;
    longint acc;
    longint s;
    u   = longint'(k) << (30 - (SINE_ADDR_BITS - 2));
    u2  = (u * u) >>> 30;
    acc = poly_coef(5);
    for (int i = 4; i >= 0; i--) acc = poly_coef(i) + q30_product(acc, u2);
    s = q30_product(acc, u);
    if (s < 0) s = 0;
    s = (s + (64'sd1 << 14)) >>> 15;
    if (s > 32767) s = 32767;
    return int'(s);
  endfunction

  // one sample tick: glide update, waveform from the old phase, phase advance
  task automatic advance_oscillator(input logic [STEP_W-1:0] tgt);
    longint diff;
    longint mag;
    int     t;
    int     d;
    int     v;
    t = int'(osc_phase[PHASE_BITS-1 -: 16]);
    if (tgt != osc_target) begin
      osc_target = tgt;
      if (osc_glide == 0) begin
        osc_step  = tgt;
        osc_ramp  = '0;
        osc_delta = 0;
      end else begin
        diff = longint'({32'd0, tgt}) - longint'({32'd0, osc_step});
        mag  = (diff < 0 ? -diff : diff) / longint'({48'd0, osc_glide});
        osc_delta = (diff < 0) ? -mag : mag;
        osc_ramp  = osc_glide;
      end
    end
    case (osc_wave)
      WAVE_SINE:     v = sine_lut[osc_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
      WAVE_TRIANGLE: begin
        d = t - 32768;
        if (d < 0) d = -d;
        v = 2 * d - 32768;
      end
      WAVE_SAW_UP:   v = t - 32768;
      WAVE_SAW_DOWN: v = 32768 - t;
      default:       v = 0;
    endcase
    if (v > 32767) v = 32767;
    if (osc_ramp != 0) begin
      osc_ramp = osc_ramp - 1'b1;
      if (osc_ramp == 0) osc_step = osc_target;
      else osc_step = osc_step + osc_delta[STEP_W-1:0];
    end
    osc_phase = osc_phase + {osc_step, {(PHASE_BITS - STEP_W){1'b0}}};
    pending_samples.push_back(v[SAMPLE_W-1:0]);
  endtask

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // send one sample request, with an occasional gap before it
  task automatic send_step(input logic [STEP_W-1:0] tgt);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tgt;
    do @(posedge clk); while (!s_axis_tready);
    advance_oscillator(tgt);
  endtask

  // stop requests and wait until every sample is back
  task automatic drain_samples();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // write both registers while the block is idle
  task automatic set_config(input logic [WAVE_W-1:0] wave, input logic [GLIDE_W-1:0] glide);
    drain_samples();
    cfg_valid <= 1'b1;
    cfg_index <= REG_WAVE_SELECT;
    cfg_data  <= {{(CFG_DATA_W - WAVE_W){1'b0}}, wave};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_GLIDE_SAMPLES;
    cfg_data  <= glide;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    osc_wave  = wave;
    osc_glide = glide;
  endtask

  function automatic logic [STEP_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 65535);
      3:       return 32'h7FFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h7FFF_FFFF);
    endcase
  endfunction

  // every waveform code, the t = 0 saturation, step extremes
  task automatic test_wave_shapes();
    for (int w = 0; w < 4; w++) begin
      set_config(w[WAVE_W-1:0], '0);
      send_step(32'h8000_0000);
      send_step(32'h8000_0000);
    end
    for (int w = 4; w < 8; w++) begin
      set_config(w[WAVE_W-1:0], '0);
      send_step(32'h8000_0000);
    end
    send_step(32'h0000_0000);
    send_step(32'h7FFF_FFFF);
  endtask

  // rising and falling glides, same target, glide change mid-ramp, glide extremes
  task automatic test_glide_cases();
    set_config(WAVE_SAW_UP, 16'd3);
    repeat (4) send_step(32'h0100_0000);
    repeat (2) send_step(32'h0010_0000);
    set_config(WAVE_TRIANGLE, 16'd5);
    repeat (2) send_step(32'h0010_0000);
    repeat (2) send_step(32'h0200_0000);
    set_config(WAVE_SINE, 16'hFFFF);
    repeat (2) send_step(32'h8000_0000);
    set_config(WAVE_SAW_DOWN, 16'd0);
    send_step(32'h1000_0000);
  endtask

  // phases of random settings, each a run of held targets; glides may be cut short
  task automatic test_random_traffic();
    int                 sent;
    int                 phase_no;
    int                 segs;
    int                 hold;
    int                 lim;
    logic [STEP_W-1:0]  tgt;
    logic [WAVE_W-1:0]  wave;
    logic [GLIDE_W-1:0] glide;
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      wave = (phase_no < 8) ? phase_no[WAVE_W-1:0] : WAVE_W'($urandom_range(0, 7));
      if (phase_no == 0) glide = '0;
      else if (phase_no == 1) glide = 16'hFFFF;
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2: glide = '0;
          8:       glide = 16'hFFFF - GLIDE_W'($urandom_range(0, 3));
          9:       glide = GLIDE_W'($urandom_range(17, 65535));
          default: glide = GLIDE_W'($urandom_range(1, 16));
        endcase
      end
      set_config(wave, glide);
      segs = $urandom_range(3, 8);
      for (int s = 0; s < segs; s++) begin
        tgt = (s == 0 && $urandom_range(0, 1) == 1) ? osc_target : pick_target();
        lim = (int'(glide) + 3 > 40) ? 40 : int'(glide) + 3;
        hold = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(1, lim);
        for (int i = 0; i < hold; i++) begin
          send_step(tgt);
          sent++;
          if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        end
      end
      phase_no++;
    end
  endtask

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (rst) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted sample with the oldest pending one
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with no request pending", m_axis_tdata, 'x);
      end else begin
        want_sample = pending_samples.pop_front();
        if (m_axis_tdata !== want_sample)
          report_mismatch("sample_out", m_axis_tdata, want_sample);
      end
    end
  end

  // watchdog on cycles without any accepted request, sample or register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("gliding_multi_waveform_oscillator_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    osc_phase      = '0;
    osc_step       = '0;
    osc_target     = '0;
    osc_delta      = 0;
    osc_ramp       = '0;
    osc_wave       = '0;
    osc_glide      = '0;
    // full-cycle sine table by quarter-wave symmetry
    for (int i = 0; i < SINE_SIZE; i++) begin
      sine_lut[i] = sine_quarter(((i >> QBITS) & 1) ? QSIZE - (i % QSIZE) : i % QSIZE);
      if ((i >> QBITS) & 2) sine_lut[i] = -sine_lut[i];
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_wave_shapes();
    test_glide_cases();
    test_random_traffic();

    drain_samples();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gliding_multi_waveform_oscillator_core verification clean");
    end else begin
      $display("gliding_multi_waveform_oscillator_core verification failed");
    end
    $finish;
  end

endmodule
